@@ rtl/iis_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iis_pkg
// Shared types and constants of the streaming integral image core.
// ----------------------------------------------------------------------------
package iis_pkg;

    localparam int PIX_W     = 8;
    localparam int SUM_W     = 28;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

    typedef struct packed {
        logic row_zero;
        logic row_end;
        logic frame_end;
    } t_job_ctl;

endpackage
`default_nettype wire

@@ rtl/iis_pixel_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iis_pixel_if
// Pixel channel: valid/ready handshake with one grey pixel per word.
// ----------------------------------------------------------------------------
interface iis_pixel_if
    import iis_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface
`default_nettype wire

@@ rtl/iis_sum_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iis_sum_if
// Result channel: summed-area value with row and frame end flags.
// ----------------------------------------------------------------------------
interface iis_sum_if
    import iis_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] area_sum;
    logic             row_end;
    logic             frame_end;

    modport source (output valid, output area_sum, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input area_sum, input row_end, input frame_end,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/iis_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iis_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/iis_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iis_front
// Accepts pixels, keeps size registers, position counters and row sum,
// and classifies each pixel for the back end.
// ----------------------------------------------------------------------------
module iis_front
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]               i_cfg_idx,
    input  wire  [CFG_W-1:0]                   i_cfg_data,
    input  wire                                i_valid,
    input  wire  [PIX_W-1:0]                   i_pixel,
    output logic                               o_ready,
    input  wire                                i_q_full,
    output logic                               o_push,
    output logic [$clog2(MAX_WIDTH)-1:0]       o_col,
    output logic [$clog2(MAX_WIDTH)+PIX_W-1:0] o_run,
    output t_job_ctl                           o_ctl
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int RSW = CW + PIX_W;
    localparam int WCW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int HCW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    logic [CFG_W-1:0] r_width, r_height;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [RSW-1:0]   r_run;

    logic [WCW-1:0] w_cfg, w_lim;
    logic [HCW-1:0] h_cfg, h_lim;
    logic           last_col, last_row;
    logic [RSW-1:0] n_run;

    always_comb begin
        w_cfg = WCW'(r_width);
        h_cfg = HCW'(r_height);
        if (w_cfg == '0) begin
            w_lim = WCW'(1);
        end else if (w_cfg > WCW'(MAX_WIDTH)) begin
            w_lim = WCW'(MAX_WIDTH);
        end else begin
            w_lim = w_cfg;
        end
        if (h_cfg == '0) begin
            h_lim = HCW'(1);
        end else if (h_cfg > HCW'(MAX_HEIGHT)) begin
            h_lim = HCW'(MAX_HEIGHT);
        end else begin
            h_lim = h_cfg;
        end
        last_col = (WCW'(r_col) + WCW'(1)) >= w_lim;
        last_row = (HCW'(r_row) + HCW'(1)) >= h_lim;
        n_run    = r_run + RSW'(i_pixel);
    end

    assign o_ready         = !i_q_full;
    assign o_push          = i_valid && o_ready;
    assign o_col           = r_col;
    assign o_run           = n_run;
    assign o_ctl.row_zero  = (r_row == '0);
    assign o_ctl.row_end   = last_col;
    assign o_ctl.frame_end = last_col && last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_RESET;
            r_height <= SIZE_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_run    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_push) begin
                if (last_col) begin
                    r_col <= '0;
                    r_run <= '0;
                    if (last_row) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + RW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                    r_run <= n_run;
                end
            end
        end
    end

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_ctl.row_end) |=> (r_col == '0 && r_run == '0))
        else $error("column or row sum did not wrap after row end");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_ctl.frame_end) |=> (r_row == '0))
        else $error("row counter did not wrap after frame end");
endmodule
`default_nettype wire

@@ rtl/iis_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iis_queue
// Short register queue between front and back ends.
// ----------------------------------------------------------------------------
module iis_queue #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 2
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire  [DATA_W-1:0] i_data,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_nempty,
    output logic [DATA_W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [NW-1:0]     r_cnt;

    assign o_full   = (r_cnt == NW'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_data   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + NW'(1);
                2'b01:   r_cnt <= r_cnt - NW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("word pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_nempty))
        else $error("word popped from empty queue");
endmodule
`default_nettype wire

@@ rtl/iis_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iis_back
// Reads the line store, adds the above-row sum, writes it back and
// holds the result word in an output register.
// ----------------------------------------------------------------------------
module iis_back
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_nempty,
    input  wire  [$clog2(MAX_WIDTH)-1:0]       i_col,
    input  wire  [$clog2(MAX_WIDTH)+PIX_W-1:0] i_run,
    input  wire  t_job_ctl                     i_ctl,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic [SUM_W-1:0]                   o_area_sum,
    output logic                               o_row_end,
    output logic                               o_frame_end
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RSW = CW + PIX_W;

    logic             r_s1_v;
    logic [CW-1:0]    r_s1_col;
    logic [RSW-1:0]   r_s1_run;
    t_job_ctl         r_s1_ctl;
    logic             r_fwd;
    logic [SUM_W-1:0] r_fwd_sum;
    logic             r_o_v;

    logic             s1_fire;
    logic [SUM_W-1:0] rdata, above, sum;

    assign s1_fire = r_s1_v && (!r_o_v || i_ready);
    assign o_pop   = i_nempty && (!r_s1_v || s1_fire);

    iis_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (sum),
        .i_re    (o_pop),
        .i_raddr (i_col),
        .o_rdata (rdata)
    );

    always_comb begin
        if (r_s1_ctl.row_zero) begin
            above = '0;
        end else if (r_fwd) begin
            above = r_fwd_sum;
        end else begin
            above = rdata;
        end
        sum = above + SUM_W'(r_s1_run);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_col  <= i_col;
            r_s1_run  <= i_run;
            r_s1_ctl  <= i_ctl;
            r_fwd_sum <= sum;
        end
        if (s1_fire) begin
            o_area_sum  <= sum;
            o_row_end   <= r_s1_ctl.row_end;
            o_frame_end <= r_s1_ctl.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_fwd  <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_v <= 1'b1;
                r_fwd  <= s1_fire && (i_col == r_s1_col);
            end else if (s1_fire) begin
                r_s1_v <= 1'b0;
                r_fwd  <= 1'b0;
            end
            r_o_v <= s1_fire || (r_o_v && !i_ready);
        end
    end

    assign o_valid = r_o_v;

    a_fwd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_v)
        else $error("bypass flag set with no word in lookup stage");

    a_frame_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && o_frame_end) |-> o_row_end)
        else $error("frame end without row end");
endmodule
`default_nettype wire

@@ rtl/integral_image_stream_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// integral_image_stream_core
// Streaming summed-area table over raster-order grey pixels.
// ----------------------------------------------------------------------------
//  channel   dir  fields                          handshake
//  i_pix     in   pixel[7:0]                      valid / ready
//  o_sum     out  area_sum[27:0] row_end frame_end valid / ready
//  i_cfg_*   in   idx 0 frame_width, 1 frame_height  write enable only
//
//  one word per cycle sustained while o_sum is ready; result word passes
//  through queue slot, line store read and output register, with
//  bypass of the line store write for one-pixel-wide frames
//  synchronous reset, no line store clearing pass after reset
//  output register and queue buffer a result stall before it stops intake
// ----------------------------------------------------------------------------
module integral_image_stream_core
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    iis_pixel_if.sink            i_pix,
    iis_sum_if.source            o_sum,
    input  wire                  i_cfg_we,
    input  wire  [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [CFG_W-1:0]     i_cfg_data
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RSW = CW + PIX_W;
    localparam int QW  = CW + RSW + $bits(t_job_ctl);

    logic           push, q_full, pop, q_nempty;
    logic [CW-1:0]  f_col, b_col;
    logic [RSW-1:0] f_run, b_run;
    t_job_ctl       f_ctl, b_ctl;
    logic [QW-1:0]  q_out;

    iis_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_pix.valid),
        .i_pixel    (i_pix.pixel),
        .o_ready    (i_pix.ready),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_col      (f_col),
        .o_run      (f_run),
        .o_ctl      (f_ctl)
    );

    iis_queue #(
        .DATA_W (QW),
        .DEPTH  (2)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   ({f_col, f_run, f_ctl}),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_nempty (q_nempty),
        .o_data   (q_out)
    );

    assign {b_col, b_run, b_ctl} = q_out;

    iis_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nempty    (q_nempty),
        .i_col       (b_col),
        .i_run       (b_run),
        .i_ctl       (b_ctl),
        .o_pop       (pop),
        .o_valid     (o_sum.valid),
        .i_ready     (o_sum.ready),
        .o_area_sum  (o_sum.area_sum),
        .o_row_end   (o_sum.row_end),
        .o_frame_end (o_sum.frame_end)
    );
endmodule
`default_nettype wire

@@ tb/tb_integral_image_stream_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integral_image_stream_core
// Self-checking bench for the streaming integral image core.
// Grey pixels enter through a valid/ready channel with random gaps. A
// behavioral summed-area model in the bench works out every output word.
// A sink process applies random back pressure and compares each word, field
// by field, with the oldest prediction. Frame sizes change between phases and
// in the middle of a frame. Out-of-range sizes are covered, then random
// frames follow.
// ----------------------------------------------------------------------------
module tb_integral_image_stream_core;
    import iis_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int MAX_W       = 1024;
    localparam int MAX_H       = 1024;
    localparam int IDLE_MAX    = 16;
    localparam int RAND_PIXELS = 650;
    localparam int TAIL_CYCLES = 10;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [SUM_W-1:0] area_sum;
        logic             row_end;
        logic             frame_end;
    } t_area_word;

    typedef enum int {PAT_RANDOM, PAT_EXTREME, PAT_FULL, PAT_DIM} t_pix_pattern;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    iis_pixel_if pix_if();
    iis_sum_if   sum_if();

    integral_image_stream_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_sum      (sum_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // summed-area model state
    logic [SUM_W-1:0] line_sums [MAX_W];
    logic [SUM_W-1:0] row_run;
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;
    t_area_word       expected_sums [$];

    int src_idle     = IDLE_MAX;
    int snk_idle     = IDLE_MAX;
    int pixels_sent  = 0;
    int frames_seen  = 0;
    int size_writes  = 0;
    int error_count  = 0;
    int cycle_count  = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d words outstanding", $time,
                     cycle_count, expected_sums.size());
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                              input int unsigned lim);
        if (v == '0) return 1;
        if (v > lim) return lim;
        return 32'(v);
    endfunction

    function automatic t_area_word integrate_pixel(input logic [PIX_W-1:0] px);
        t_area_word       w;
        logic [SUM_W-1:0] above;
        logic             last_col;
        logic             last_row;
        row_run = row_run + SUM_W'(px);
        above = (row_pos != 0) ? line_sums[col_pos] : '0;
        w.area_sum = above + row_run;
        line_sums[col_pos] = w.area_sum;
        last_col = (col_pos + 1 >= clamp_dim(cfg_width, MAX_W));
        last_row = (row_pos + 1 >= clamp_dim(cfg_height, MAX_H));
        w.row_end = last_col;
        w.frame_end = last_col && last_row;
        if (last_col) begin
            col_pos = 0;
            row_run = '0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return w;
    endfunction

    function automatic int draw_wait(input int lim);
        if (lim == 0 || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, lim);
    endfunction

    function automatic logic [PIX_W-1:0] draw_pixel(input t_pix_pattern pat);
        case (pat)
            PAT_RANDOM:  return PIX_W'($urandom_range(0, 255));
            PAT_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
            PAT_FULL:    return 8'hff;
            default:     return PIX_W'($urandom_range(0, 7));
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        gap = draw_wait(src_idle);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        do @(posedge i_clk); while (pix_if.ready !== 1'b1);
        expected_sums.push_back(integrate_pixel(px));
        pixels_sent++;
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_frame_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_FRAME_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        cfg_width = w;
        i_cfg_idx  <= REG_FRAME_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        cfg_height = h;
        i_cfg_we <= 1'b0;
        size_writes++;
    endtask

    task automatic finish_frame(input t_pix_pattern pat);
        do send_pixel(draw_pixel(pat)); while (col_pos != 0 || row_pos != 0);
    endtask

    task automatic test_small_frame();
        logic [PIX_W-1:0] pix [9];
        pix = '{8'hff, 8'h00, 8'h01, 8'h80, 8'hff, 8'hff, 8'h00, 8'h7f, 8'hc8};
        set_frame_size(11'd3, 11'd3);
        foreach (pix[k]) send_pixel(pix[k]);
    endtask

    task automatic test_size_clamp();
        // zero sizes act as one, so every word ends a frame
        set_frame_size(11'd0, 11'd0);
        repeat (3) send_pixel(draw_pixel(PAT_RANDOM));
    endtask

    task automatic test_mid_frame_resize();
        set_frame_size(11'd5, 11'd4);
        repeat (8) send_pixel(draw_pixel(PAT_EXTREME));
        // column already past the new width, row ends at once
        set_frame_size(11'd2, 11'd4);
        repeat (3) send_pixel(draw_pixel(PAT_EXTREME));
        // row already past the new height, frame ends with this row
        set_frame_size(11'd2, 11'd2);
        repeat (2) send_pixel(draw_pixel(PAT_EXTREME));
    endtask

    task automatic test_size_limits();
        // oversized sizes clamp, so no early row or frame end, then shrink
        src_idle = 0;
        snk_idle = IDLE_MAX;
        set_frame_size(11'd2047, 11'd2);
        repeat (40) send_pixel(draw_pixel(PAT_FULL));
        set_frame_size(11'd4, 11'd2);
        finish_frame(PAT_FULL);
        src_idle = IDLE_MAX;
        snk_idle = 0;
        set_frame_size(11'd1, 11'd2047);
        repeat (40) send_pixel(draw_pixel(PAT_FULL));
        set_frame_size(11'd1, 11'd2);
        finish_frame(PAT_RANDOM);
    endtask

    task automatic test_random_frames();
        int           rand_count;
        int           start;
        int unsigned  w;
        int unsigned  h;
        t_pix_pattern pat;
        rand_count = 0;
        while (rand_count < RAND_PIXELS) begin
            case ($urandom_range(0, 7))
                0:       w = 0;
                1:       w = $urandom_range(17, 48);
                default: w = $urandom_range(1, 16);
            endcase
            h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
            src_idle = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            snk_idle = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            pat = t_pix_pattern'($urandom_range(0, 3));
            start = pixels_sent;
            set_frame_size(CFG_W'(w), CFG_W'(h));
            if ($urandom_range(0, 5) == 0) begin
                // width may only shrink mid-frame so no unwritten line entry is read
                repeat ($urandom_range(1, 3 * clamp_dim(CFG_W'(w), MAX_W)))
                    send_pixel(draw_pixel(pat));
                set_frame_size(CFG_W'($urandom_range(1, clamp_dim(CFG_W'(w), MAX_W))),
                               CFG_W'($urandom_range(1, 8)));
                if (col_pos != 0 || row_pos != 0) finish_frame(pat);
            end else begin
                repeat ($urandom_range(1, 2)) finish_frame(pat);
            end
            rand_count += pixels_sent - start;
        end
    endtask

    initial begin : result_sink
        int         stall;
        t_area_word want;
        sum_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = draw_wait(snk_idle);
            if (stall > 0) begin
                sum_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            sum_if.ready <= 1'b1;
            do @(posedge i_clk); while (sum_if.valid !== 1'b1);
            if (expected_sums.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %0d %b %b",
                         $time, sum_if.area_sum, sum_if.row_end, sum_if.frame_end);
                error_count++;
            end else begin
                want = expected_sums.pop_front();
                if (sum_if.area_sum !== want.area_sum) begin
                    $display("%0t: area_sum expected %0d actual %0d", $time,
                             want.area_sum, sum_if.area_sum);
                    error_count++;
                end
                if (sum_if.row_end !== want.row_end) begin
                    $display("%0t: row_end expected %b actual %b", $time,
                             want.row_end, sum_if.row_end);
                    error_count++;
                end
                if (sum_if.frame_end !== want.frame_end) begin
                    $display("%0t: frame_end expected %b actual %b", $time,
                             want.frame_end, sum_if.frame_end);
                    error_count++;
                end
                if (sum_if.frame_end === 1'b1) frames_seen++;
            end
        end
    end

    initial begin
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= REG_FRAME_WIDTH;
        i_cfg_data   <= '0;
        i_rst_n      <= 1'b0;
        cfg_width  = SIZE_RESET;
        cfg_height = SIZE_RESET;
        row_run    = '0;
        col_pos    = 0;
        row_pos    = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_small_frame();
        test_size_clamp();
        test_mid_frame_resize();
        test_size_limits();
        test_random_frames();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_sums.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, expected_sums.size());
            error_count++;
        end
        $display("run covered %0d pixels over %0d completed frames and %0d size settings",
                 pixels_sent, frames_seen, size_writes);
        $display("%0d mismatches in %0d cycles", error_count, cycle_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/iis_pkg.sv
rtl/iis_pixel_if.sv
rtl/iis_sum_if.sv
rtl/iis_ram.sv
rtl/iis_front.sv
rtl/iis_queue.sv
rtl/iis_back.sv
rtl/integral_image_stream_core.sv
tb/tb_integral_image_stream_core.sv
